@@ rtl/pfq_pkg.sv @@
// pfq_pkg: shared types and constants of the packet FIFO with length queue.
// Item and result word layouts, operation codes, register indexes, command/status structs.
// No dependencies.
package pfq_pkg;

	localparam int DEF_DATA_DEPTH  = 2048;
	localparam int DEF_QUEUE_DEPTH = 256;

	// capacity registers after reset (clamped to the depths)
	localparam int RST_DATA_CAP   = 2048;
	localparam int RST_PACKET_CAP = 256;

	localparam int CFG_DATA_W   = 12;
	localparam int DATA_CAP_W   = 12;
	localparam int PACKET_CAP_W = 9;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_STATUS = 2'd3
	} op_t;

	typedef enum logic {
		REG_DATA_CAP   = 1'b0,
		REG_PACKET_CAP = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		op_t        operation;
		logic [7:0] data_byte;
		logic [7:0] packet_len;
	} item_t;

	typedef struct packed {
		logic [7:0]  read_byte;
		logic        byte_valid;
		logic        packet_end;
		logic        data_overflow;
		logic        packet_overflow;
		logic [7:0]  packets_stored;
		logic [10:0] bytes_stored;
		logic [10:0] next_packet_size;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic take;
		logic check;
		logic write;
		logic clear;
		logic rd_fetch;
		logic rd_pop;
		logic st_fetch;
		logic st_load;
		logic cfg_write;
	} pfq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
	} pfq_stat_t;

endpackage

@@ rtl/pfq_ctrl.sv @@
// pfq_ctrl: sequencer of the packet FIFO; one word at a time.
// Depends on pfq_pkg (op_t, pfq_cmd_t, pfq_stat_t).
module pfq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  pfq_pkg::op_t      item_op,
	input  logic              cfg_valid,
	input  pfq_pkg::pfq_stat_t stat,
	output logic              item_stall,
	output logic              cfg_ready,
	output pfq_pkg::pfq_cmd_t cmd
);
	import pfq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_WRITE,
		S_CLEAR,
		S_RD_FETCH,
		S_RD_POP,
		S_ST_FETCH,
		S_ST_LOAD
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						unique case (item_op)
							OP_WRITE:  state_q <= S_CHECK;
							OP_READ:   state_q <= S_RD_FETCH;
							OP_CLEAR:  state_q <= S_CLEAR;
							OP_STATUS: state_q <= S_ST_FETCH;
						endcase
					end
				end
				S_CHECK:    state_q <= S_WRITE;
				S_WRITE:    state_q <= S_ST_FETCH;
				S_CLEAR:    state_q <= S_ST_FETCH;
				S_RD_FETCH: state_q <= S_RD_POP;
				S_RD_POP:   state_q <= S_ST_FETCH;
				S_ST_FETCH: state_q <= S_ST_LOAD;
				S_ST_LOAD: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
			endcase
		end
	end

	// config is taken only when idle and no word is offered in the same cycle
	always_comb begin
		cmd           = '0;
		cmd.take      = (state_q == S_IDLE) && item_valid;
		cmd.cfg_write = (state_q == S_IDLE) && cfg_valid && !item_valid;
		cmd.check     = (state_q == S_CHECK);
		cmd.write     = (state_q == S_WRITE);
		cmd.clear     = (state_q == S_CLEAR);
		cmd.rd_fetch  = (state_q == S_RD_FETCH);
		cmd.rd_pop    = (state_q == S_RD_POP);
		cmd.st_fetch  = (state_q == S_ST_FETCH);
		cmd.st_load   = (state_q == S_ST_LOAD) && stat.out_free;
	end

	assign item_stall = (state_q != S_IDLE);
	assign cfg_ready  = (state_q == S_IDLE) && !item_valid;

endmodule

@@ rtl/pfq_dpath.sv @@
// pfq_dpath: byte ring, end-index queue, pointers, flags and result register.
// Depends on pfq_pkg; driven by pfq_ctrl through pfq_cmd_t.
module pfq_dpath #(
	parameter int DATA_DEPTH  = pfq_pkg::DEF_DATA_DEPTH,
	parameter int QUEUE_DEPTH = pfq_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pfq_pkg::pfq_cmd_t                 cmd,
	input  pfq_pkg::item_t                    item,
	input  pfq_pkg::cfg_reg_t                 cfg_index,
	input  logic [pfq_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              result_stall,
	output logic                              result_valid,
	output pfq_pkg::result_t                  result,
	output pfq_pkg::pfq_stat_t                stat
);
	import pfq_pkg::*;

	localparam int DW  = $clog2(DATA_DEPTH);
	localparam int QW  = $clog2(QUEUE_DEPTH);
	localparam int DCW = $clog2(DATA_DEPTH + 1);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW  = ((DCW > 8) ? DCW : 8) + 1;
	localparam logic [DCW-1:0] DCAP_RST =
		(DATA_DEPTH < RST_DATA_CAP) ? DCW'(DATA_DEPTH) : DCW'(RST_DATA_CAP);
	localparam logic [QCW-1:0] PCAP_RST =
		(QUEUE_DEPTH < RST_PACKET_CAP) ? QCW'(QUEUE_DEPTH) : QCW'(RST_PACKET_CAP);

	function automatic logic [DW-1:0] d_next(input logic [DW-1:0] i, input logic [DCW-1:0] cap);
		logic [DCW-1:0] n;
		n = DCW'(i) + DCW'(1);
		return (n >= cap) ? '0 : DW'(n);
	endfunction

	function automatic logic [QW-1:0] q_next(input logic [QW-1:0] i, input logic [QCW-1:0] cap);
		logic [QCW-1:0] n;
		n = QCW'(i) + QCW'(1);
		return (n >= cap) ? '0 : QW'(n);
	endfunction

	function automatic logic [DCW-1:0] d_dist(input logic [DW-1:0] bot, input logic [DW-1:0] top,
		input logic [DCW-1:0] cap);
		logic [DCW-1:0] b;
		logic [DCW-1:0] t;
		b = DCW'(bot);
		t = DCW'(top);
		return (t >= b) ? (t - b) : (cap - b + t);
	endfunction

	function automatic logic [QCW-1:0] q_dist(input logic [QW-1:0] bot, input logic [QW-1:0] top,
		input logic [QCW-1:0] cap);
		logic [QCW-1:0] b;
		logic [QCW-1:0] t;
		b = QCW'(bot);
		t = QCW'(top);
		return (t >= b) ? (t - b) : (cap - b + t);
	endfunction

	function automatic logic [DCW-1:0] d_clamp(input logic [CFG_DATA_W-1:0] v);
		logic [DATA_CAP_W-1:0] c;
		c = v[DATA_CAP_W-1:0];
		if (32'(c) < 32'd2) return DCW'(2);
		if (32'(c) > 32'(DATA_DEPTH)) return DCW'(DATA_DEPTH);
		return DCW'(c);
	endfunction

	function automatic logic [QCW-1:0] q_clamp(input logic [CFG_DATA_W-1:0] v);
		logic [PACKET_CAP_W-1:0] c;
		c = v[PACKET_CAP_W-1:0];
		if (32'(c) < 32'd2) return QCW'(2);
		if (32'(c) > 32'(QUEUE_DEPTH)) return QCW'(QUEUE_DEPTH);
		return QCW'(c);
	endfunction

	// storage
	logic [7:0]    byte_mem [DATA_DEPTH];
	logic [DW-1:0] end_mem  [QUEUE_DEPTH];
	logic [7:0]    byte_rd_q;
	logic [DW-1:0] end_rd_q;

	// control state
	logic [DCW-1:0] dcap_q;
	logic [QCW-1:0] pcap_q;
	logic [DW-1:0]  bh_q, bt_q;
	logic [QW-1:0]  qh_q, qt_q;
	logic           dovf_q, povf_q, discard_q;
	logic [7:0]     btc_q;
	logic           result_valid_q;

	// payload
	item_t          item_q;
	logic [7:0]     rbyte_q;
	logic           bvalid_q, pend_q;
	result_t        result_q;

	// combinational terms
	logic [DCW-1:0] byte_cnt;
	logic [QCW-1:0] pkt_cnt;
	logic [DCW-1:0] nsize;
	logic           dfull, pfull, start_w, store_w, end_w, push_w;
	logic [7:0]     remain_w;
	logic [DW-1:0]  bh_n_w, bt_pop;
	logic           has_pkt, pop_valid, pop_end;
	logic [31:0]    pc32, bc32, ns32;
	result_t        result_w;

	always_comb begin
		byte_cnt = d_dist(bt_q, bh_q, dcap_q);
		pkt_cnt  = q_dist(qt_q, qh_q, pcap_q);
		dfull    = (SW'(byte_cnt) + SW'(item_q.packet_len)) >= SW'(dcap_q);
		pfull    = (pkt_cnt == (pcap_q - QCW'(1)));

		start_w = (btc_q == 8'd0);
		if (start_w) remain_w = (item_q.packet_len == 8'd0) ? 8'd0 : item_q.packet_len - 8'd1;
		else         remain_w = btc_q - 8'd1;
		store_w = !discard_q && !(start_w && (item_q.packet_len == 8'd0));
		end_w   = (remain_w == 8'd0);
		push_w  = end_w && !discard_q;
		bh_n_w  = store_w ? d_next(bh_q, dcap_q) : bh_q;

		has_pkt   = (qh_q != qt_q);
		pop_valid = (bt_q != end_rd_q);
		bt_pop    = pop_valid ? d_next(bt_q, dcap_q) : bt_q;
		pop_end   = (bt_pop == end_rd_q);

		nsize = has_pkt ? d_dist(bt_q, end_rd_q, dcap_q) : '0;
		pc32  = 32'(pkt_cnt);
		bc32  = 32'(byte_cnt);
		ns32  = 32'(nsize);

		result_w.read_byte        = rbyte_q;
		result_w.byte_valid       = bvalid_q;
		result_w.packet_end       = pend_q;
		result_w.data_overflow    = dovf_q;
		result_w.packet_overflow  = povf_q;
		result_w.packets_stored   = pc32[7:0];
		result_w.bytes_stored     = bc32[10:0];
		result_w.next_packet_size = ns32[10:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcap_q         <= DCAP_RST;
			pcap_q         <= PCAP_RST;
			bh_q           <= '0;
			bt_q           <= '0;
			qh_q           <= '0;
			qt_q           <= '0;
			dovf_q         <= 1'b0;
			povf_q         <= 1'b0;
			discard_q      <= 1'b0;
			btc_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.cfg_write) begin
				unique case (cfg_index)
					REG_DATA_CAP:   dcap_q <= d_clamp(cfg_data);
					REG_PACKET_CAP: pcap_q <= q_clamp(cfg_data);
				endcase
				bh_q      <= '0;
				bt_q      <= '0;
				qh_q      <= '0;
				qt_q      <= '0;
				dovf_q    <= 1'b0;
				povf_q    <= 1'b0;
				discard_q <= 1'b0;
				btc_q     <= '0;
			end else begin
				if (cmd.check && start_w) begin
					dovf_q    <= dfull;
					povf_q    <= pfull;
					discard_q <= dfull | pfull;
				end
				if (cmd.write) begin
					btc_q <= remain_w;
					bh_q  <= bh_n_w;
					if (push_w) qh_q <= q_next(qh_q, pcap_q);
					if (end_w) discard_q <= 1'b0;
				end
				if (cmd.clear) begin
					dovf_q <= 1'b0;
					povf_q <= 1'b0;
				end
				if (cmd.rd_pop && has_pkt) begin
					bt_q <= bt_pop;
					if (pop_end) qt_q <= q_next(qt_q, pcap_q);
				end
			end
			if (cmd.st_load)         result_valid_q <= 1'b1;
			else if (!result_stall)  result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q   <= item;
			rbyte_q  <= '0;
			bvalid_q <= 1'b0;
			pend_q   <= 1'b0;
		end
		if (cmd.rd_pop && has_pkt) begin
			rbyte_q  <= pop_valid ? byte_rd_q : 8'd0;
			bvalid_q <= pop_valid;
			pend_q   <= pop_end;
		end
		if (cmd.st_load) result_q <= result_w;
	end

	always_ff @(posedge clk) begin
		if (cmd.write && store_w) byte_mem[bh_q] <= item_q.data_byte;
		if (cmd.rd_fetch) byte_rd_q <= byte_mem[bt_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.write && push_w) end_mem[qh_q] <= bh_n_w;
		if (cmd.rd_fetch || cmd.st_fetch) end_rd_q <= end_mem[qt_q];
	end

	assign result_valid  = result_valid_q;
	assign result        = result_q;
	assign stat.out_free = !result_valid_q || !result_stall;

endmodule

@@ rtl/packet_fifo_with_length_queue_unit.sv @@
// Packet FIFO with length queue: one word in, one status word out.
// Write: check, store, status fetch, status load. Read: fetch, pop, status fetch, status load.
// Clear: clear, status fetch, status load. Status-only op: status fetch, status load. The load
// waits on result_stall; one word at a time, over the single-port ring and end-index memories.
// arst_n clears pointers, flags and control; capacities reset to 2048/256 (clamped to depth);
// ring and queue contents are not cleared.
module packet_fifo_with_length_queue_unit #(
	parameter int DATA_DEPTH  = pfq_pkg::DEF_DATA_DEPTH,
	parameter int QUEUE_DEPTH = pfq_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// item channel
	input  logic                           item_valid,
	output logic                           item_stall,
	input  pfq_pkg::item_t                 item,
	// result channel
	output logic                           result_valid,
	input  logic                           result_stall,
	output pfq_pkg::result_t               result,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  pfq_pkg::cfg_reg_t              cfg_index,
	input  logic [pfq_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pfq_pkg::*;

	// Controller and datapath talk only through these two structs.
	pfq_cmd_t  cmd;
	pfq_stat_t stat;

	// The sequencer takes a word only in its idle state, so item_stall is high for the
	// whole time one word is being worked on. Configuration writes are taken in idle
	// when no word is offered; a capacity write empties the FIFO.
	pfq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_op    (item.operation),
		.cfg_valid  (cfg_valid),
		.stat       (stat),
		.item_stall (item_stall),
		.cfg_ready  (cfg_ready),
		.cmd        (cmd)
	);

	// Datapath: byte ring plus end-index queue, each one memory with a registered read.
	// Write word: check pass (overflow flags on a packet start), then store/push pass.
	// Read word: fetch head byte and head end index, then pop.
	// Every word ends by refetching the head end index to build the status word,
	// which lands in an output register so the next word can enter while it waits.
	pfq_dpath #(
		.DATA_DEPTH  (DATA_DEPTH),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.stat         (stat)
	);

endmodule

@@ rtl/pfq_checker.sv @@
// pfq_checker: port-level checks of the packet FIFO, bound to the top level.
// Depends on pfq_pkg and packet_fifo_with_length_queue_unit.
module pfq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           item_valid,
	input logic                           item_stall,
	input logic                           result_valid,
	input logic                           result_stall,
	input pfq_pkg::result_t               result,
	input logic                           cfg_ready
);
	import pfq_pkg::*;

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// one word at a time: the cycle after a take the input is stalled
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input not stalled after a word was taken");

	// config only lands while the sequencer is idle
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !item_stall)
		else $error("config port ready while a word is in work");

	// no popped byte means the byte field reads zero
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.byte_valid |-> result.read_byte == 8'd0)
		else $error("read_byte nonzero without byte_valid");

endmodule

bind packet_fifo_with_length_queue_unit pfq_checker u_pfq_checker (.*);
